### rtl/key_record_stream_validator_assert.svh
// ----------------------------------------------------------------------------
// Key record stream validator assertion macros
// Concurrent assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef KEY_RECORD_STREAM_VALIDATOR_ASSERT_SVH
`define KEY_RECORD_STREAM_VALIDATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
// The using module provides clk and rst_n.
`define KRSV_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("krsv assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KRSV_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("krsv assertion failed");

`endif

### rtl/krsv_pkg.sv
// ----------------------------------------------------------------------------
// Key record stream validator package
// Item types, field layout constants, status codes and the CRC step.
// ----------------------------------------------------------------------------
package krsv_pkg;

  localparam int KEYID_START    = 8;
  localparam int PUBKEY_START   = 16;
  localparam int LABEL_START    = 81;
  localparam int RESERVED_START = 105;

  localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
  localparam logic [31:0] CRC_POLY = 32'hedb8_8320;

  localparam logic [7:0] VERSION_ONE = 8'd1;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_KEYID  = 2'd1;
  localparam logic [1:0] KIND_PUBKEY = 2'd2;
  localparam logic [1:0] KIND_LABEL  = 2'd3;

  localparam logic [2:0] ST_PARSED    = 3'd0;
  localparam logic [2:0] ST_LENGTH    = 3'd1;
  localparam logic [2:0] ST_MAGIC     = 3'd2;
  localparam logic [2:0] ST_VERSION   = 3'd3;
  localparam logic [2:0] ST_ALGORITHM = 3'd4;
  localparam logic [2:0] ST_RESERVED  = 3'd5;
  localparam logic [2:0] ST_CHECKSUM  = 3'd6;

  // Bit positions of the sticky error flags.
  localparam int FLAG_MAGIC    = 0;
  localparam int FLAG_VERSION  = 1;
  localparam int FLAG_ALGO     = 2;
  localparam int FLAG_RESERVED = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } krsv_in_t;

  typedef struct packed {
    logic [7:0] field_byte;
    logic [1:0] field_kind;
    logic [6:0] field_offset;
    logic       done_res;
    logic [2:0] status;
  } krsv_out_t;

  // A byte after classification by its position in the record.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic [1:0] field_kind;
    logic [6:0] field_offset;
    logic       chk_magic;
    logic [1:0] magic_idx;
    logic       chk_version;
    logic       chk_algo;
    logic       len_lo;
    logic       len_hi;
    logic       chk_rsvd;
    logic       crc_en;
    logic       sum_en;
    logic [1:0] sum_idx;
    logic       len_ok;
  } krsv_cls_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h4c;
      2'd1:    b = 8'h48;
      2'd2:    b = 8'h41;
      default: b = 8'h4b;
    endcase
    return b;
  endfunction

  // One byte of the reflected CRC-32, eight shift steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

### rtl/krsv_fifo.sv
// ----------------------------------------------------------------------------
// Key record stream validator two-entry queue
// Small first-in first-out buffer with push/full and pop/empty.
// ----------------------------------------------------------------------------
module krsv_fifo #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     push_data,
  output logic full,
  input  logic pop,
  output T     pop_data,
  output logic empty
);

  T           mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/krsv_front.sv
// ----------------------------------------------------------------------------
// Key record stream validator front end
// Counts record bytes and tags each byte with its field and check duties.
// ----------------------------------------------------------------------------
module krsv_front
  import krsv_pkg::*;
#(
  parameter int RECORD_BYTES = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      take,
  input  krsv_in_t  item,
  output krsv_cls_t cls
);

  localparam int CNT_W = $clog2(RECORD_BYTES + 2);

  localparam logic [CNT_W-1:0] REC_END   = CNT_W'(RECORD_BYTES);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(RECORD_BYTES + 1);
  localparam logic [CNT_W-1:0] LAST_POS  = CNT_W'(RECORD_BYTES - 1);
  localparam logic [CNT_W-1:0] SUM_AT    = CNT_W'(RECORD_BYTES - 4);
  localparam logic [CNT_W-1:0] KEYID_AT  = CNT_W'(KEYID_START);
  localparam logic [CNT_W-1:0] PUBKEY_AT = CNT_W'(PUBKEY_START);
  localparam logic [CNT_W-1:0] LABEL_AT  = CNT_W'(LABEL_START);
  localparam logic [CNT_W-1:0] RSVD_AT   = CNT_W'(RESERVED_START);

  logic [CNT_W-1:0] pos_r;
  logic [CNT_W-1:0] pos_nxt;
  logic             in_rec;
  logic [CNT_W-1:0] sum_off;

  assign in_rec  = (pos_r < REC_END);
  assign sum_off = pos_r - SUM_AT;

  always_comb begin
    cls              = '0;
    cls.data_byte    = item.data_byte;
    cls.last_byte    = item.last_byte;
    cls.field_kind   = KIND_NONE;
    cls.field_offset = 7'd0;
    cls.chk_magic    = (pos_r < CNT_W'(4));
    cls.magic_idx    = pos_r[1:0];
    cls.chk_version  = (pos_r == CNT_W'(4));
    cls.chk_algo     = (pos_r == CNT_W'(5));
    cls.len_lo       = (pos_r == CNT_W'(6));
    cls.len_hi       = (pos_r == CNT_W'(7));
    cls.chk_rsvd     = (pos_r >= RSVD_AT) && (pos_r < SUM_AT);
    cls.crc_en       = (pos_r < SUM_AT);
    cls.sum_en       = in_rec && (pos_r >= SUM_AT);
    cls.sum_idx      = sum_off[1:0];
    // The byte position is one less than the record size exactly when the last record byte arrives.
    cls.len_ok       = (pos_r == LAST_POS);
    if (pos_r >= KEYID_AT && pos_r < PUBKEY_AT) begin
      cls.field_kind   = KIND_KEYID;
      cls.field_offset = 7'(pos_r - KEYID_AT);
    end else if (pos_r >= PUBKEY_AT && pos_r < LABEL_AT) begin
      cls.field_kind   = KIND_PUBKEY;
      cls.field_offset = 7'(pos_r - PUBKEY_AT);
    end else if (pos_r >= LABEL_AT && pos_r < RSVD_AT) begin
      cls.field_kind   = KIND_LABEL;
      cls.field_offset = 7'(pos_r - LABEL_AT);
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    if (take) begin
      if (item.last_byte) begin
        pos_nxt = '0;
      end else if (pos_r < CNT_LIMIT) begin
        pos_nxt = pos_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

### rtl/krsv_back.sv
// ----------------------------------------------------------------------------
// Key record stream validator back end
// Runs the CRC and field checks on tagged bytes and builds each result.
// ----------------------------------------------------------------------------
module krsv_back
  import krsv_pkg::*;
#(
  parameter int RECORD_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  krsv_cls_t  cls,
  input  logic [7:0] expected_alg,
  output krsv_out_t  res
);

  localparam logic [15:0] REC_LEN = 16'(RECORD_BYTES);

  logic [31:0] crc_r;
  logic [31:0] crc_nxt;
  logic [15:0] len_r;
  logic [15:0] len_nxt;
  logic [31:0] sum_r;
  logic [31:0] sum_nxt;
  logic [3:0]  flags_r;
  logic [3:0]  flags_nxt;
  logic [2:0]  status;

  always_comb begin
    crc_nxt   = cls.crc_en ? crc_byte(crc_r, cls.data_byte) : crc_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    flags_nxt = flags_r;
    if (cls.len_lo) begin
      len_nxt = {len_r[15:8], cls.data_byte};
    end
    if (cls.len_hi) begin
      len_nxt = {cls.data_byte, len_r[7:0]};
    end
    if (cls.sum_en) begin
      sum_nxt = sum_r | ({24'd0, cls.data_byte} << {cls.sum_idx, 3'd0});
    end
    if (cls.chk_magic && cls.data_byte != magic_byte(cls.magic_idx)) begin
      flags_nxt[FLAG_MAGIC] = 1'b1;
    end
    if (cls.chk_version && cls.data_byte != VERSION_ONE) begin
      flags_nxt[FLAG_VERSION] = 1'b1;
    end
    if (cls.chk_algo && cls.data_byte != expected_alg) begin
      flags_nxt[FLAG_ALGO] = 1'b1;
    end
    if (cls.chk_rsvd && cls.data_byte != 8'd0) begin
      flags_nxt[FLAG_RESERVED] = 1'b1;
    end
  end

  // The first failing check in priority order sets the status.
  always_comb begin
    status = ST_PARSED;
    if (cls.last_byte) begin
      if (!cls.len_ok || len_nxt != REC_LEN) begin
        status = ST_LENGTH;
      end else if (flags_nxt[FLAG_MAGIC]) begin
        status = ST_MAGIC;
      end else if (flags_nxt[FLAG_VERSION]) begin
        status = ST_VERSION;
      end else if (flags_nxt[FLAG_ALGO]) begin
        status = ST_ALGORITHM;
      end else if (flags_nxt[FLAG_RESERVED]) begin
        status = ST_RESERVED;
      end else if (sum_nxt != ~crc_nxt) begin
        status = ST_CHECKSUM;
      end
    end
  end

  always_comb begin
    res.field_byte   = cls.data_byte;
    res.field_kind   = cls.field_kind;
    res.field_offset = cls.field_offset;
    res.done_res     = cls.last_byte;
    res.status       = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_INIT;
      len_r   <= '0;
      sum_r   <= '0;
      flags_r <= '0;
    end else if (take) begin
      if (cls.last_byte) begin
        crc_r   <= CRC_INIT;
        len_r   <= '0;
        sum_r   <= '0;
        flags_r <= '0;
      end else begin
        crc_r   <= crc_nxt;
        len_r   <= len_nxt;
        sum_r   <= sum_nxt;
        flags_r <= flags_nxt;
      end
    end
  end

endmodule

### rtl/key_record_stream_validator.sv
// ----------------------------------------------------------------------------
// Key record stream validator
// Checks a fixed-size key record arriving byte by byte and tags its fields.
//
//   Channel   Direction  Ports                         Transfer when
//   input     in         in_push, in_full, in_data     in_push && !in_full
//   result    out        out_empty, out_pop, out_data  out_pop && !out_empty
//   config    in         cfg_wr_en, cfg_wr_data        cfg_wr_en
//
// Each byte gives one result. A byte is classified in the cycle it is taken,
// waits in a two-entry queue, and the back end runs the CRC-32 byte step and
// the checks while moving it into a two-entry result queue. Sustained rate
// is one byte per cycle while the result side keeps popping. A stalled
// result side fills both queues, then in_full rises.
// Reset is synchronous and leaves both queues empty and the record cleared.
// ----------------------------------------------------------------------------
module key_record_stream_validator
  import krsv_pkg::*;
#(
  parameter int RECORD_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  krsv_in_t   in_data,
  output logic       out_empty,
  input  logic       out_pop,
  output krsv_out_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic [7:0] exp_alg_r;
  logic       in_take;
  krsv_cls_t  cls_in;
  krsv_cls_t  cls_out;
  logic       mid_full;
  logic       mid_empty;
  logic       res_full;
  logic       back_take;
  krsv_out_t  res;

  assign in_full   = mid_full;
  assign in_take   = in_push && !mid_full;
  assign back_take = !mid_empty && !res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_alg_r <= 8'd0;
    end else if (cfg_wr_en) begin
      exp_alg_r <= cfg_wr_data;
    end
  end

  krsv_front #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (in_take),
    .item  (in_data),
    .cls   (cls_in)
  );

  krsv_fifo #(
    .T (krsv_cls_t)
  ) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_take),
    .push_data (cls_in),
    .full      (mid_full),
    .pop       (back_take),
    .pop_data  (cls_out),
    .empty     (mid_empty)
  );

  krsv_back #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (back_take),
    .cls          (cls_out),
    .expected_alg (exp_alg_r),
    .res          (res)
  );

  krsv_fifo #(
    .T (krsv_out_t)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (back_take),
    .push_data (res),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_data),
    .empty     (out_empty)
  );

endmodule

### rtl/krsv_checker.sv
// ----------------------------------------------------------------------------
// Key record stream validator port checker
// Watches the top-level ports for result and handshake consistency.
// ----------------------------------------------------------------------------
`include "key_record_stream_validator_assert.svh"

module krsv_checker
  import krsv_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_empty,
  input logic      out_pop,
  input krsv_out_t out_data
);

  logic shown;

  assign shown = !out_empty;

  // A status is reported only on the final byte of a record.
  `KRSV_ASSERT_NOW(a_status_on_done, shown && !out_data.done_res, out_data.status == ST_PARSED)

  // Bytes outside the tagged fields carry no offset.
  `KRSV_ASSERT_NOW(a_none_no_offset, shown && out_data.field_kind == KIND_NONE, out_data.field_offset == 7'd0)

  // Key id bytes stay within the eight-byte key id field.
  `KRSV_ASSERT_NOW(a_keyid_range, shown && out_data.field_kind == KIND_KEYID, out_data.field_offset < 7'd8)

  // A result that is not taken stays on the ports unchanged.
  `KRSV_ASSERT_NEXT(a_result_holds, shown && !out_pop, !out_empty && $stable(out_data))

endmodule

bind key_record_stream_validator krsv_checker u_krsv_checker (.*);
